[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the combination lock RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[rtl/bcl_pkg.sv]
// ----------------------------------------------------------------------------
// Combination lock package
// Shared widths, mode and result codes, and control structs.
// ----------------------------------------------------------------------------
package bcl_pkg;

    // Password store depth and derived widths
    localparam int MAX_ENTRIES = 16;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    // Fixed field widths
    localparam int MASK_W  = 4;
    localparam int ENTRY_W = 3;
    localparam int WIN_W   = 16;
    localparam int CODE_W  = 48;
    localparam int DLEN_W  = 5;
    localparam int CIDX_W  = 2;

    // Reset values of the configuration registers
    localparam logic [WIN_W-1:0]  WINDOW_RST = 16'd3000;
    localparam logic [CODE_W-1:0] CODE_RST   = 48'd82596;
    localparam logic [DLEN_W-1:0] DLEN_RST   = 5'd6;

    // Button codes
    localparam logic [MASK_W-1:0] BTN_SET = 4'b1000;
    localparam logic [MASK_W-1:0] BTN_0   = 4'b0001;
    localparam logic [MASK_W-1:0] BTN_1   = 4'b0010;
    localparam logic [MASK_W-1:0] BTN_2   = 4'b0100;
    localparam logic [MASK_W-1:0] BTN_NONE = 4'b0000;

    // Configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        CFG_WINDOW   = 2'd0,
        CFG_CODE     = 2'd1,
        CFG_LENGTH   = 2'd2,
        CFG_RESERVED = 2'd3
    } t_cfg_idx;

    // Lock modes
    typedef enum logic [2:0] {
        M_INIT     = 3'd0,
        M_WINDOW   = 3'd1,
        M_SETTING  = 3'd2,
        M_DEFAULT  = 3'd3,
        M_READY    = 3'd4,
        M_GUESSING = 3'd5,
        M_CHECKING = 3'd6,
        M_UNLOCKED = 3'd7
    } t_mode;

    // Check outcome codes
    typedef enum logic [1:0] {
        CHK_NONE = 2'd0,
        CHK_OK   = 2'd1,
        CHK_BAD  = 2'd2,
        CHK_RSV  = 2'd3
    } t_check;

    // Store control from the sequencer
    typedef struct packed {
        logic               sec_wr;
        logic               gue_wr;
        logic               def_load;
        logic [CNT_W-1:0]   def_n;
        logic [IDX_W-1:0]   wr_idx;
        logic [ENTRY_W-1:0] wr_entry;
        logic [CNT_W-1:0]   sec_count;
        logic [CNT_W-1:0]   gue_count;
    } t_store_ctl;

    // One result item
    typedef struct packed {
        t_mode  mode;
        logic   locked_led;
        logic   setting_led;
        logic   window_led;
        t_check check;
    } t_result;

    // True for a single press of button 0, 1 or 2
    function automatic logic single_low(input logic [MASK_W-1:0] b);
        return (b == BTN_0) || (b == BTN_1) || (b == BTN_2);
    endfunction

endpackage

[rtl/bcl_fsm.sv]
// ----------------------------------------------------------------------------
// Combination lock sequencer
// Mode state machine, set-window countdown, entry counts and LED flags.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bcl_fsm
    import bcl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [MASK_W-1:0] i_mask,
    input  logic [WIN_W-1:0]  i_window_ticks,
    input  logic [DLEN_W-1:0] i_default_length,
    input  logic              i_match,
    output t_store_ctl        o_store_ctl,
    output t_result           o_result
);

    t_mode            r_mode, n_mode;
    logic [WIN_W-1:0] r_countdown, n_countdown;
    logic [CNT_W-1:0] r_sec_count, n_sec_count;
    logic [CNT_W-1:0] r_gue_count, n_gue_count;
    logic             r_led_locked, n_led_locked;
    logic             r_led_setting, n_led_setting;
    logic             r_led_window, n_led_window;
    t_check           w_check;
    logic             w_single;
    logic [CNT_W-1:0] w_def_n;

    assign w_single = single_low(i_mask);
    assign w_def_n  = (i_default_length > DLEN_W'(MAX_ENTRIES))
                    ? CNT_W'(MAX_ENTRIES) : i_default_length[CNT_W-1:0];

    // Next mode
    always_comb begin
        n_mode = r_mode;
        case (r_mode)
            M_INIT:     n_mode = M_WINDOW;
            M_WINDOW: begin
                if (i_mask == BTN_SET) begin
                    n_mode = M_SETTING;
                end else if (r_countdown == '0) begin
                    n_mode = M_DEFAULT;
                end
            end
            M_SETTING: begin
                if (i_mask == BTN_SET) begin
                    n_mode = M_READY;
                end
            end
            M_DEFAULT:  n_mode = M_READY;
            M_READY:    n_mode = M_GUESSING;
            M_GUESSING: begin
                if (!w_single && i_mask == BTN_SET) begin
                    n_mode = M_CHECKING;
                end
            end
            M_CHECKING: n_mode = i_match ? M_UNLOCKED : M_GUESSING;
            M_UNLOCKED: begin
                if (i_mask != BTN_NONE) begin
                    n_mode = M_GUESSING;
                end
            end
            default:    n_mode = M_INIT;
        endcase
    end

    // Counters, LEDs, store writes and check outcome
    always_comb begin
        n_countdown   = r_countdown;
        n_sec_count   = r_sec_count;
        n_gue_count   = r_gue_count;
        n_led_locked  = r_led_locked;
        n_led_setting = r_led_setting;
        n_led_window  = r_led_window;
        w_check       = CHK_NONE;
        o_store_ctl   = '0;
        o_store_ctl.def_n     = w_def_n;
        o_store_ctl.wr_entry  = i_mask[ENTRY_W-1:0];
        o_store_ctl.sec_count = r_sec_count;
        o_store_ctl.gue_count = r_gue_count;
        case (r_mode)
            M_INIT: begin
                n_led_window = 1'b1;
                n_countdown  = i_window_ticks;
            end
            M_WINDOW: begin
                if (i_mask == BTN_SET) begin
                    n_led_setting = 1'b1;
                    n_sec_count   = '0;
                end else if (r_countdown != '0) begin
                    n_countdown = r_countdown - WIN_W'(1);
                end
            end
            M_SETTING: begin
                if (i_mask == BTN_SET) begin
                    n_led_setting = 1'b0;
                    n_led_window  = 1'b0;
                end else if (w_single && r_sec_count < CNT_W'(MAX_ENTRIES)) begin
                    o_store_ctl.sec_wr = i_step;
                    o_store_ctl.wr_idx = r_sec_count[IDX_W-1:0];
                    n_sec_count        = r_sec_count + CNT_W'(1);
                end
            end
            M_DEFAULT: begin
                o_store_ctl.def_load = i_step;
                n_sec_count          = w_def_n;
                n_led_window         = 1'b0;
            end
            M_READY: begin
                n_led_locked = 1'b1;
                n_gue_count  = '0;
            end
            M_GUESSING: begin
                if (w_single && r_gue_count < CNT_W'(MAX_ENTRIES)) begin
                    o_store_ctl.gue_wr = i_step;
                    o_store_ctl.wr_idx = r_gue_count[IDX_W-1:0];
                    n_gue_count        = r_gue_count + CNT_W'(1);
                end
            end
            M_CHECKING: begin
                if (i_match) begin
                    w_check      = CHK_OK;
                    n_led_locked = 1'b0;
                end else begin
                    w_check     = CHK_BAD;
                    n_gue_count = '0;
                end
            end
            M_UNLOCKED: begin
                if (i_mask != BTN_NONE) begin
                    n_led_locked = 1'b1;
                    n_gue_count  = '0;
                end
            end
            default: begin
                w_check = CHK_NONE;
            end
        endcase
    end

    // Result of this step, taken after the update
    always_comb begin
        o_result.mode        = n_mode;
        o_result.locked_led  = n_led_locked;
        o_result.setting_led = n_led_setting;
        o_result.window_led  = n_led_window;
        o_result.check       = w_check;
    end

    // Advance state once per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= M_INIT;
            r_countdown   <= '0;
            r_sec_count   <= '0;
            r_gue_count   <= '0;
            r_led_locked  <= 1'b0;
            r_led_setting <= 1'b0;
            r_led_window  <= 1'b0;
        end else if (i_step) begin
            r_mode        <= n_mode;
            r_countdown   <= n_countdown;
            r_sec_count   <= n_sec_count;
            r_gue_count   <= n_gue_count;
            r_led_locked  <= n_led_locked;
            r_led_setting <= n_led_setting;
            r_led_window  <= n_led_window;
        end
    end

    `ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1,
        (r_sec_count <= CNT_W'(MAX_ENTRIES)) && (r_gue_count <= CNT_W'(MAX_ENTRIES)))
    `ASSERT_IMPLY(a_unlocked_led, i_clk, i_rst_n, r_mode == M_UNLOCKED, !r_led_locked)
    `ASSERT_IMPLY(a_setting_window, i_clk, i_rst_n, r_led_setting, r_led_window)

endmodule

[rtl/bcl_store.sv]
// ----------------------------------------------------------------------------
// Combination lock entry stores
// Password and guess entry registers with a length-masked parallel compare.
// ----------------------------------------------------------------------------
module bcl_store
    import bcl_pkg::*;
(
    input  logic              i_clk,
    input  t_store_ctl        i_ctl,
    input  logic [CODE_W-1:0] i_default_code,
    output logic              o_match
);

    logic [ENTRY_W-1:0] r_secret [MAX_ENTRIES];
    logic [ENTRY_W-1:0] r_guess  [MAX_ENTRIES];
    logic               w_mismatch;

    // Write password entries from the default code or from a custom press
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (i_ctl.def_load && (CNT_W'(i) < i_ctl.def_n)) begin
                r_secret[i] <= i_default_code[ENTRY_W*i +: ENTRY_W];
            end else if (i_ctl.sec_wr && (i_ctl.wr_idx == IDX_W'(i))) begin
                r_secret[i] <= i_ctl.wr_entry;
            end
        end
    end

    // Write guess entries
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (i_ctl.gue_wr && (i_ctl.wr_idx == IDX_W'(i))) begin
                r_guess[i] <= i_ctl.wr_entry;
            end
        end
    end

    // Compare lengths and every entry below the guess length
    always_comb begin
        w_mismatch = 1'b0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if ((CNT_W'(i) < i_ctl.gue_count) && (r_secret[i] != r_guess[i])) begin
                w_mismatch = 1'b1;
            end
        end
        o_match = (i_ctl.gue_count == i_ctl.sec_count) && !w_mismatch;
    end

endmodule

[rtl/button_combination_lock.sv]
// ----------------------------------------------------------------------------
// Button combination lock
// Tick-driven combination lock with a custom-password set window.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one item per tick, carrying the mask of buttons pressed
//   since the previous tick. Output channel: one result item per input item
//   (mode, three LEDs, check outcome), in order.
//   Config channel: index 0 window length, 1 default code, 2 default length.
//   Write only while idle; the port is always ready. Index 3 is ignored.
//   Path: an accepted item lands in the input register, is processed once
//   the output register is free or draining, and its result is registered.
//   Throughput: one item per cycle while the output is not stalled; the mode
//   update loops through the sequencer and the 16-entry parallel compare.
//   Reset: mode returns to init, counts and LEDs clear, configuration takes
//   its default values; entry stores are not cleared.
//   Stall: while the result waits, the input register holds one more item;
//   input ready drops only when both registers are full and output is stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module button_combination_lock
    import bcl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [MASK_W-1:0] i_button_mask,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [2:0]        o_lock_state,
    output logic              o_locked_led,
    output logic              o_setting_led,
    output logic              o_window_led,
    output logic [1:0]        o_check_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CODE_W-1:0] i_cfg_data
);

    logic              r_in_valid;
    logic [MASK_W-1:0] r_in_mask;
    logic              r_out_valid;
    t_result           r_result;
    logic [WIN_W-1:0]  r_window_ticks;
    logic [CODE_W-1:0] r_default_code;
    logic [DLEN_W-1:0] r_default_length;
    logic              w_step;
    logic              w_match;
    t_store_ctl        w_store_ctl;
    t_result           w_result;

    // Process the held item when the output register is free or draining
    assign w_step      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_step;
    assign o_cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ticks   <= WINDOW_RST;
            r_default_code   <= CODE_RST;
            r_default_length <= DLEN_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WINDOW: r_window_ticks   <= i_cfg_data[WIN_W-1:0];
                CFG_CODE:   r_default_code   <= i_cfg_data;
                CFG_LENGTH: r_default_length <= i_cfg_data[DLEN_W-1:0];
                default:    r_window_ticks   <= r_window_ticks;
            endcase
        end
    end

    // Hold the accepted item in the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_mask <= i_button_mask;
        end
    end

    // Capture the result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_result <= w_result;
        end
    end

    bcl_fsm u_fsm (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (w_step),
        .i_mask           (r_in_mask),
        .i_window_ticks   (r_window_ticks),
        .i_default_length (r_default_length),
        .i_match          (w_match),
        .o_store_ctl      (w_store_ctl),
        .o_result         (w_result)
    );

    bcl_store u_store (
        .i_clk          (i_clk),
        .i_ctl          (w_store_ctl),
        .i_default_code (r_default_code),
        .o_match        (w_match)
    );

    assign o_out_valid    = r_out_valid;
    assign o_lock_state   = r_result.mode;
    assign o_locked_led   = r_result.locked_led;
    assign o_setting_led  = r_result.setting_led;
    assign o_window_led   = r_result.window_led;
    assign o_check_result = r_result.check;

    `ASSERT_NEXT(a_step_result, i_clk, i_rst_n, w_step, r_out_valid)
    `ASSERT_IMPLY(a_check_only_here, i_clk, i_rst_n,
        r_out_valid && (r_result.check != CHK_NONE),
        (r_result.mode == M_UNLOCKED) || (r_result.mode == M_GUESSING))

endmodule
